FILE: rtl/slcfd_pkg.sv
package slcfd_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_VALUE = 2'd0;
  localparam logic [1:0] REG_MIN_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

  // Register reset values
  localparam logic [7:0] SYNC_RESET = 8'hC8;
  localparam logic [5:0] MIN_RESET  = 6'd2;
  localparam logic [5:0] MAX_RESET  = 6'd62;

  // Framing constants
  localparam logic [7:0] CRC_POLY     = 8'hD5;
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;
  localparam logic [7:0] LEN_CEILING  = 8'd62;

  // One validated frame waiting to be drained from its payload bank
  typedef struct packed {
    logic       bank;
    logic [7:0] frame_type;
    logic [5:0] plen;
  } desc_t;

endpackage

FILE: rtl/slcfd_ram.sv
module slcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/slcfd_front.sv
module slcfd_front #(
  parameter int PAYLOAD_DEPTH = 64,
  parameter int IDX_W         = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 ram_we_o,
  output logic [IDX_W:0]       ram_waddr_o,
  output logic [7:0]           ram_wdata_o,
  output logic                 desc_push_o,
  output slcfd_pkg::desc_t     desc_o
);

  typedef enum logic [3:0] {
    F_HUNT = 4'b0001,
    F_LEN  = 4'b0010,
    F_TYPE = 4'b0100,
    F_BODY = 4'b1000
  } front_state_e;

  front_state_e state_q, state_d;
  logic [7:0] sync_q;
  logic [5:0] min_q, max_q;
  logic [5:0] flen_q, flen_d;
  logic [5:0] rcv_q, rcv_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] type_q, type_d;
  logic       bank_q, bank_d;
  logic [5:0] plen;
  logic       len_ok;

  // Advance the CRC-8 by one byte, MSB first
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ slcfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Check the length byte against the fixed and configured bounds
  always_comb begin
    len_ok = (rx_byte_i >= slcfd_pkg::LEN_OVERHEAD) &&
             (rx_byte_i >= {2'b00, min_q}) &&
             (rx_byte_i <= {2'b00, max_q}) &&
             (rx_byte_i <= slcfd_pkg::LEN_CEILING) &&
             (32'(rx_byte_i) <= 32'(PAYLOAD_DEPTH) + 32'd2);
  end

  assign plen = flen_q - 6'd2;

  // Parse sync, length, type, payload and CRC
  always_comb begin
    state_d     = state_q;
    flen_d      = flen_q;
    rcv_d       = rcv_q;
    crc_d       = crc_q;
    type_d      = type_q;
    bank_d      = bank_q;
    ram_we_o    = 1'b0;
    desc_push_o = 1'b0;
    if (in_valid_i) begin
      case (state_q)
        F_HUNT: begin
          if (rx_byte_i == sync_q) begin
            state_d = F_LEN;
          end
        end
        F_LEN: begin
          if (len_ok) begin
            flen_d  = rx_byte_i[5:0];
            state_d = F_TYPE;
          end else begin
            state_d = F_HUNT;
          end
        end
        F_TYPE: begin
          type_d  = rx_byte_i;
          crc_d   = crc8_byte(8'h00, rx_byte_i);
          rcv_d   = 6'd0;
          state_d = F_BODY;
        end
        F_BODY: begin
          if (rcv_q < plen) begin
            ram_we_o = 1'b1;
            crc_d    = crc8_byte(crc_q, rx_byte_i);
            rcv_d    = rcv_q + 6'd1;
          end else begin
            state_d = F_HUNT;
            if (rx_byte_i == crc_q) begin
              desc_push_o = 1'b1;
              bank_d      = ~bank_q;
            end
          end
        end
        default: state_d = F_HUNT;
      endcase
    end
  end

  assign ram_waddr_o       = {bank_q, IDX_W'(rcv_q)};
  assign ram_wdata_o       = rx_byte_i;
  assign desc_o.bank       = bank_q;
  assign desc_o.frame_type = type_q;
  assign desc_o.plen       = plen;

  // Hold configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_HUNT;
      sync_q  <= slcfd_pkg::SYNC_RESET;
      min_q   <= slcfd_pkg::MIN_RESET;
      max_q   <= slcfd_pkg::MAX_RESET;
      flen_q  <= 6'd0;
      rcv_q   <= 6'd0;
      crc_q   <= 8'h00;
      type_q  <= 8'h00;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      flen_q  <= flen_d;
      rcv_q   <= rcv_d;
      crc_q   <= crc_d;
      type_q  <= type_d;
      bank_q  <= bank_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          slcfd_pkg::REG_SYNC_VALUE: sync_q <= cfg_data_i;
          slcfd_pkg::REG_MIN_LENGTH: min_q  <= cfg_data_i[5:0];
          slcfd_pkg::REG_MAX_LENGTH: max_q  <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/slcfd_desc_fifo.sv
module slcfd_desc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slcfd_pkg::desc_t desc_i,
  input  logic             pop_i,
  output logic             valid_o,
  output slcfd_pkg::desc_t desc_o,
  output logic [1:0]       count_o
);

  slcfd_pkg::desc_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  // Store descriptors
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign desc_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: rtl/slcfd_back.sv
module slcfd_back #(
  parameter int IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             desc_valid_i,
  input  slcfd_pkg::desc_t desc_i,
  output logic             desc_pop_o,
  output logic             ram_re_o,
  output logic [IDX_W:0]   ram_raddr_o,
  input  logic [7:0]       ram_rdata_i,
  output logic             busy_o,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       frame_type_o,
  output logic [7:0]       data_byte_o,
  output logic [5:0]       byte_index_o,
  output logic             has_data_o,
  output logic             last_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_LOAD = 3'b100
  } back_state_e;

  back_state_e      state_q, state_d;
  slcfd_pkg::desc_t cur_q, cur_d;
  logic [5:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic             run_has_data;
  logic             run_last;
  logic [7:0]       type_q;
  logic [7:0]       data_q;
  logic [5:0]       index_q;
  logic             has_data_q;
  logic             last_q;

  assign run_has_data = (cur_q.plen != 6'd0);
  assign run_last     = !run_has_data || (idx_q == cur_q.plen - 6'd1);

  // Walk the payload of one frame, one result at a time
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    desc_pop_o  = 1'b0;
    ram_re_o    = 1'b0;
    load        = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (desc_valid_i) begin
          desc_pop_o = 1'b1;
          cur_d      = desc_i;
          idx_d      = 6'd0;
          state_d    = (desc_i.plen == 6'd0) ? B_LOAD : B_READ;
        end
      end
      B_READ: begin
        ram_re_o = 1'b1;
        state_d  = B_LOAD;
      end
      B_LOAD: begin
        if (!out_valid_q || pop) begin
          load = 1'b1;
          if (run_last) begin
            state_d = B_IDLE;
          end else begin
            idx_d   = idx_q + 6'd1;
            state_d = B_READ;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign ram_raddr_o = {cur_q.bank, IDX_W'(idx_q)};
  assign busy_o      = (state_q != B_IDLE);

  // Output register: load a new result or drop the popped one
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the current descriptor and the result payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      type_q     <= cur_q.frame_type;
      data_q     <= run_has_data ? ram_rdata_i : 8'h00;
      index_q    <= run_has_data ? idx_q : 6'd0;
      has_data_q <= run_has_data;
      last_q     <= run_last;
    end
  end

  assign empty        = !out_valid_q;
  assign frame_type_o = type_q;
  assign data_byte_o  = data_q;
  assign byte_index_o = index_q;
  assign has_data_o   = has_data_q;
  assign last_o       = last_q;

endmodule

FILE: rtl/sync_length_crc8_frame_deframer_top.sv
// Sync / length / CRC-8 frame deframer.
// Input channel: one received byte per transaction on rx_byte_i, taken at a
// clock edge with push high and full low. The parser hunts for the sync
// byte, checks the length byte against min/max bounds, then collects the
// type byte, the payload and a CRC-8 (poly 0xD5) byte.
// Result channel: while empty is low the oldest result sits on the output
// ports; pop takes it. A good frame yields one result per payload byte with
// last on the final one, or a single result with has_data low when the
// payload is empty. Frames with a bad CRC are dropped without results.
// Throughput: one input byte per cycle while the parser is not stalled.
// The drain engine takes each result through a registered RAM read, then
// an output load that waits for room, and only then reads the next byte.
// Two payload banks let the parser collect the next frame while the
// previous one drains; full rises only while both banks hold frames not
// yet drained.
// Reset returns to sync hunting with default registers (sync 0xC8, length
// 2..62) and an empty result queue; no clearing pass is needed.
// A stalled receiver holds the current result and, once both banks fill,
// backs the stall up to the input through full.
module sync_length_crc8_frame_deframer_top #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_type_o,
  output logic [7:0] data_byte_o,
  output logic [5:0] byte_index_o,
  output logic       has_data_o,
  output logic       last_o
);

  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);

  logic             in_valid;
  logic             ram_we;
  logic [IDX_W:0]   ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [IDX_W:0]   ram_raddr;
  logic [7:0]       ram_rdata;
  logic             desc_push;
  slcfd_pkg::desc_t desc_in;
  logic             desc_pop;
  logic             desc_valid;
  slcfd_pkg::desc_t desc_out;
  logic [1:0]       desc_count;
  logic             back_busy;

  // Stall input while both payload banks hold undrained frames
  assign full     = ({1'b0, desc_count} + {2'b00, back_busy}) >= 3'd2;
  assign in_valid = push && !full;

  slcfd_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid),
    .rx_byte_i  (rx_byte_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .desc_push_o(desc_push),
    .desc_o     (desc_in)
  );

  slcfd_ram #(
    .WIDTH(8),
    .DEPTH(2 ** (IDX_W + 1))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  slcfd_desc_fifo u_desc_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (desc_push),
    .desc_i (desc_in),
    .pop_i  (desc_pop),
    .valid_o(desc_valid),
    .desc_o (desc_out),
    .count_o(desc_count)
  );

  slcfd_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_valid_i(desc_valid),
    .desc_i      (desc_out),
    .desc_pop_o  (desc_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .busy_o      (back_busy),
    .empty       (empty),
    .pop         (pop),
    .frame_type_o(frame_type_o),
    .data_byte_o (data_byte_o),
    .byte_index_o(byte_index_o),
    .has_data_o  (has_data_o),
    .last_o      (last_o)
  );

endmodule

FILE: rtl/slcfd_checker.sv
module slcfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] frame_type_o,
  input logic [7:0] data_byte_o,
  input logic [5:0] byte_index_o,
  input logic       has_data_o,
  input logic       last_o
);

  // A waiting result that is not taken stays put
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(frame_type_o) && $stable(data_byte_o) &&
    $stable(byte_index_o) && $stable(has_data_o) && $stable(last_o))
    else $error("result changed while stalled");

  // An empty-payload result is a lone, zeroed, final result
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !has_data_o |-> last_o && data_byte_o == 8'h00 && byte_index_o == 6'd0)
    else $error("malformed empty-payload result");

  // Payload positions never exceed the longest payload
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> byte_index_o <= 6'd59)
    else $error("byte index out of range");

endmodule

bind sync_length_crc8_frame_deframer_top slcfd_checker u_checker (.*);
